[design/cascaded_pid_levitation_control_defines.svh]
// ----------------------------------------------------------------------------
// Cascaded PID levitation control - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CASCADED_PID_LEVITATION_CONTROL_DEFINES_SVH
`define CASCADED_PID_LEVITATION_CONTROL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CPID_ASSERT_SAME(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CPID_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cpid_lev_pkg.sv]
// ----------------------------------------------------------------------------
// Cascaded PID levitation control - package
// Field widths, sensor scale factors, register indexes, item types and the
// saturating fixed-point helpers shared by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpid_lev_pkg;

    // Converter and PWM full scale
    localparam int ADC_MAX = 1023;
    localparam int PWM_MAX = 254;

    // Counts to Q8.24 meters and amperes
    localparam int POS_SCALE = 838861 / ADC_MAX;
    localparam int CUR_SCALE = (38130036 + ADC_MAX / 2) / ADC_MAX;

    // Field and register widths
    localparam int CNT_W      = 10;
    localparam int SP_W       = 20;
    localparam int GAIN_W     = 25;
    localparam int ILIM_W     = 26;
    localparam int VLIM_W     = 29;
    localparam int DUTY_W     = 8;
    localparam int DEMAND_W   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    // Datapath widths
    localparam int WORD_W  = 32;
    localparam int SUM_W   = 36;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
    localparam int GAIN_FRAC = 16;

    // floor(n / 5) = (n * RECIP_5) >> RECIP_SHIFT, exact for 32-bit n
    localparam logic [MUL_A_W-1:0] RECIP_5 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 34;

    // Divider: quotient bits and remainder width
    localparam int QUOT_W = $clog2(PWM_MAX + 1);
    localparam int REM_W  = VLIM_W + QUOT_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_GAIN_P   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_GAIN_I   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT   = 3'd7;

    // Register reset values
    localparam logic [SP_W-1:0]   RST_POS_SETPOINT = 20'd83886;
    localparam logic [GAIN_W-1:0] RST_POS_GAIN_P   = 25'd6553600;
    localparam logic [GAIN_W-1:0] RST_POS_GAIN_I   = 25'd32768;
    localparam logic [GAIN_W-1:0] RST_POS_GAIN_D   = 25'd9830400;
    localparam logic [GAIN_W-1:0] RST_CUR_GAIN_P   = 25'd786432;
    localparam logic [GAIN_W-1:0] RST_CUR_GAIN_I   = 25'd1966080;
    localparam logic [ILIM_W-1:0] RST_CUR_LIMIT    = 26'd13874758;
    localparam logic [VLIM_W-1:0] RST_VOLT_LIMIT   = 29'd165423350;

    // Input item
    typedef struct packed {
        logic [CNT_W-1:0] position_count;
        logic [CNT_W-1:0] current_count;
    } sample_t;

    // Result item
    typedef struct packed {
        logic [DUTY_W-1:0]   pwm_duty;
        logic [DEMAND_W-1:0] current_demand;
    } result_t;

    // Sign-extend a 32-bit word to the sum width
    function automatic logic signed [SUM_W-1:0] sext(input logic signed [WORD_W-1:0] v);
        return {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // Saturate a wide sum to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (&v[SUM_W-1:WORD_W-1] || ~|v[SUM_W-1:WORD_W-1])
            return v[WORD_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // Q9.16 gain product: floor shift, then saturate
    function automatic logic signed [WORD_W-1:0] gain_scale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> GAIN_FRAC;
        if (&s[PROD_W-1:WORD_W-1] || ~|s[PROD_W-1:WORD_W-1])
            return s[WORD_W-1:0];
        else if (s[PROD_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // floor(19 * lim / 4), the numerator for the /5 reciprocal
    function automatic logic [WORD_W-1:0] quarter19(input logic [VLIM_W-1:0] lim);
        logic [VLIM_W+4:0] t;
        t = {1'b0, lim, 4'b0} + {4'b0, lim, 1'b0} + {5'b0, lim};
        return t[VLIM_W+4:2];
    endfunction

    // Integrator step with reset-type anti-windup
    function automatic logic signed [WORD_W-1:0] integrate(
        input logic signed [WORD_W-1:0] acc,
        input logic signed [WORD_W-1:0] incr,
        input logic [VLIM_W-1:0]        lim,
        input logic [VLIM_W-1:0]        back
    );
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] l;
        logic signed [WORD_W-1:0] b;
        a = sext(acc);
        l = $signed({{(SUM_W-VLIM_W){1'b0}}, lim});
        b = $signed({{(WORD_W-VLIM_W){1'b0}}, back});
        if (a > -l && a < l)
            return sat32(a + sext(incr));
        else if (a >= l)
            return b;
        else
            return -b;
    endfunction

endpackage

`default_nettype wire

[design/cpid_lev_mul.sv]
// ----------------------------------------------------------------------------
// Cascaded PID levitation control - shared multiplier
// Unsigned 32-bit by signed 33-bit multiply with a registered product; every
// gain product and reciprocal product of the controller goes through it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_lev_mul (
    input  wire logic                                    clk,
    input  wire logic [cpid_lev_pkg::MUL_A_W-1:0]        a,
    input  wire logic signed [cpid_lev_pkg::MUL_B_W-1:0] b,
    output logic signed [cpid_lev_pkg::PROD_W-1:0]       product
);

    logic signed [cpid_lev_pkg::PROD_W-1:0] product_reg;
    logic signed [cpid_lev_pkg::PROD_W-1:0] product_next;

    // Signed multiply, operand a zero-extended
    assign product_next = $signed({1'b0, a}) * b;

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

[design/cascaded_pid_levitation_control.sv]
// ----------------------------------------------------------------------------
// Cascaded PID levitation control - top level
// Outer position PID feeding an inner current PI loop, with a PWM duty output.
// ----------------------------------------------------------------------------
// Each sample item (two 10-bit sensor counts) produces one result item: the
// PWM duty and the current demand. A sample is in work from the edge that
// accepts it until its result is loaded, and no new sample is taken in
// that time. The work is seven products through the single shared
// multiplier, with the integrator, sum and clamp steps between them, then
// an 8-step restoring divider for the duty. sample_stall is high while a
// sample is in work and during reset. The result sits in an output
// register, so a new sample is taken while the previous result still waits;
// the finished result leaves only once that register is free. Configuration
// writes are taken while no sample is in work.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_pid_levitation_control_defines.svh"

module cascaded_pid_levitation_control (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    // sample channel
    input  wire logic                                       sample_valid,
    output logic                                            sample_stall,
    input  wire cpid_lev_pkg::sample_t                      sample,
    // result channel
    output logic                                            result_valid,
    input  wire logic                                       result_stall,
    output cpid_lev_pkg::result_t                           result,
    // configuration channel
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [cpid_lev_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [cpid_lev_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_M1    = 4'd1;
    localparam logic [3:0] ST_M2    = 4'd2;
    localparam logic [3:0] ST_M3    = 4'd3;
    localparam logic [3:0] ST_M4    = 4'd4;
    localparam logic [3:0] ST_INT_P = 4'd5;
    localparam logic [3:0] ST_SUM_P = 4'd6;
    localparam logic [3:0] ST_ERR_I = 4'd7;
    localparam logic [3:0] ST_M5    = 4'd8;
    localparam logic [3:0] ST_M6    = 4'd9;
    localparam logic [3:0] ST_M7    = 4'd10;
    localparam logic [3:0] ST_INT_C = 4'd11;
    localparam logic [3:0] ST_SUM_C = 4'd12;
    localparam logic [3:0] ST_SCALE = 4'd13;
    localparam logic [3:0] ST_DIV   = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    localparam int WORD_W = cpid_lev_pkg::WORD_W;
    localparam int VLIM_W = cpid_lev_pkg::VLIM_W;
    localparam int ILIM_W = cpid_lev_pkg::ILIM_W;
    localparam int SP_W   = cpid_lev_pkg::SP_W;
    localparam int GAIN_W = cpid_lev_pkg::GAIN_W;
    localparam int QUOT_W = cpid_lev_pkg::QUOT_W;
    localparam int REM_W  = cpid_lev_pkg::REM_W;
    localparam int DUTY_W = cpid_lev_pkg::DUTY_W;
    localparam int DEM_W  = cpid_lev_pkg::DEMAND_W;
    localparam int DIVC_W = $clog2(QUOT_W);

    // Configuration registers
    logic [SP_W-1:0]   pos_setpoint_reg;
    logic [GAIN_W-1:0] pos_gain_p_reg;
    logic [GAIN_W-1:0] pos_gain_i_reg;
    logic [GAIN_W-1:0] pos_gain_d_reg;
    logic [GAIN_W-1:0] cur_gain_p_reg;
    logic [GAIN_W-1:0] cur_gain_i_reg;
    logic [ILIM_W-1:0] cur_limit_reg;
    logic [VLIM_W-1:0] volt_limit_reg;

    // Controller state
    logic signed [WORD_W-1:0] error_prev_reg;
    logic signed [WORD_W-1:0] pos_integral_reg;
    logic signed [WORD_W-1:0] cur_integral_reg;

    // Sequencer and working registers
    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic signed [WORD_W-1:0] err_reg;
    logic signed [WORD_W-1:0] diff_reg;
    logic signed [WORD_W-1:0] prop_reg;
    logic signed [WORD_W-1:0] deriv_reg;
    logic signed [WORD_W-1:0] incr_reg;
    logic signed [WORD_W-1:0] ei_reg;
    logic [ILIM_W-1:0]        ie_reg;
    logic [DEM_W-1:0]         demand_reg;
    logic [DEM_W-1:0]         demand_next;
    logic [VLIM_W-1:0]        u_reg;
    logic [VLIM_W-1:0]        u_next;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         div_reg;
    logic [QUOT_W-1:0]        quot_reg;
    logic [DIVC_W-1:0]        div_cnt_reg;

    // Output register
    logic                  result_valid_reg;
    cpid_lev_pkg::result_t result_reg;

    // Shared multiplier
    logic [cpid_lev_pkg::MUL_A_W-1:0]        mul_a;
    logic signed [cpid_lev_pkg::MUL_B_W-1:0] mul_b;
    logic signed [cpid_lev_pkg::PROD_W-1:0]  product;

    // Derived values
    logic                     sample_take;
    logic                     result_free;
    logic [SP_W-1:0]          pos_meas;
    logic [ILIM_W-1:0]        cur_meas;
    logic signed [WORD_W-1:0] err_next;
    logic signed [WORD_W-1:0] prod_scaled;
    logic [VLIM_W-1:0]        prod_back;
    logic [VLIM_W-1:0]        cur_limit_ext;
    logic signed [WORD_W-1:0] id_sum;
    logic signed [WORD_W-1:0] u_sum;
    logic signed [WORD_W-1:0] lim_neg;
    logic [REM_W-1:0]         rem_trial;
    logic                     quot_bit;

    assign sample_stall = !rst_n || (state_reg != ST_IDLE);
    assign cfg_ready    = rst_n && (state_reg == ST_IDLE);
    assign sample_take  = sample_valid && !sample_stall;
    assign result_free  = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sensor scaling and position error
    assign pos_meas = SP_W'(32'(sample.position_count) * cpid_lev_pkg::POS_SCALE);
    assign cur_meas = ILIM_W'(32'(sample.current_count) * cpid_lev_pkg::CUR_SCALE);
    assign err_next = $signed({{(WORD_W-SP_W){1'b0}}, pos_setpoint_reg})
                    - $signed({{(WORD_W-SP_W){1'b0}}, pos_meas});

    // Product post-processing
    assign prod_scaled   = cpid_lev_pkg::gain_scale(product);
    assign prod_back     = product[VLIM_W+cpid_lev_pkg::RECIP_SHIFT-1:cpid_lev_pkg::RECIP_SHIFT];
    assign cur_limit_ext = {{(VLIM_W-ILIM_W){1'b0}}, cur_limit_reg};

    // Outer loop sum, clamped to [-limit, 0] and negated
    assign id_sum  = cpid_lev_pkg::sat32(cpid_lev_pkg::sext(prop_reg)
                   + cpid_lev_pkg::sext(pos_integral_reg)
                   + cpid_lev_pkg::sext(deriv_reg));
    assign lim_neg = -$signed({{(WORD_W-ILIM_W){1'b0}}, cur_limit_reg});

    always_comb
    begin
        if (!id_sum[WORD_W-1])
            demand_next = '0;
        else if (id_sum <= lim_neg)
            demand_next = cur_limit_reg;
        else
            demand_next = DEM_W'(-id_sum);
    end

    // Inner loop sum, clamped to [0, vlimit]
    assign u_sum = cpid_lev_pkg::sat32(cpid_lev_pkg::sext(prop_reg)
                 + cpid_lev_pkg::sext(cur_integral_reg));

    always_comb
    begin
        if (u_sum[WORD_W-1] || u_sum == '0)
            u_next = '0;
        else if (u_sum > $signed({{(WORD_W-VLIM_W){1'b0}}, volt_limit_reg}))
            u_next = volt_limit_reg;
        else
            u_next = u_sum[VLIM_W-1:0];
    end

    // Restoring divider step
    assign quot_bit  = (rem_reg >= div_reg);
    assign rem_trial = rem_reg - div_reg;

    // Multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_M1:
            begin
                mul_a = 32'(pos_gain_p_reg);
                mul_b = {err_reg[WORD_W-1], err_reg};
            end
            ST_M2:
            begin
                mul_a = 32'(pos_gain_d_reg);
                mul_b = {diff_reg[WORD_W-1], diff_reg};
            end
            ST_M3:
            begin
                mul_a = 32'(pos_gain_i_reg);
                mul_b = {err_reg[WORD_W-1], err_reg};
            end
            ST_M4:
            begin
                mul_a = cpid_lev_pkg::RECIP_5;
                mul_b = $signed({1'b0, cpid_lev_pkg::quarter19(cur_limit_ext)});
            end
            ST_M5:
            begin
                mul_a = 32'(cur_gain_p_reg);
                mul_b = {ei_reg[WORD_W-1], ei_reg};
            end
            ST_M6:
            begin
                mul_a = 32'(cur_gain_i_reg);
                mul_b = {ei_reg[WORD_W-1], ei_reg};
            end
            ST_M7:
            begin
                mul_a = cpid_lev_pkg::RECIP_5;
                mul_b = $signed({1'b0, cpid_lev_pkg::quarter19(volt_limit_reg)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cpid_lev_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // Sequencer next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = sample_take ? ST_M1 : ST_IDLE;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_INT_P;
            ST_INT_P: state_next = ST_SUM_P;
            ST_SUM_P: state_next = ST_ERR_I;
            ST_ERR_I: state_next = ST_M5;
            ST_M5:    state_next = ST_M6;
            ST_M6:    state_next = ST_M7;
            ST_M7:    state_next = ST_INT_C;
            ST_INT_C: state_next = ST_SUM_C;
            ST_SUM_C: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = (div_cnt_reg == '0) ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = result_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            error_prev_reg   <= '0;
            pos_integral_reg <= '0;
            cur_integral_reg <= '0;
            pos_setpoint_reg <= cpid_lev_pkg::RST_POS_SETPOINT;
            pos_gain_p_reg   <= cpid_lev_pkg::RST_POS_GAIN_P;
            pos_gain_i_reg   <= cpid_lev_pkg::RST_POS_GAIN_I;
            pos_gain_d_reg   <= cpid_lev_pkg::RST_POS_GAIN_D;
            cur_gain_p_reg   <= cpid_lev_pkg::RST_CUR_GAIN_P;
            cur_gain_i_reg   <= cpid_lev_pkg::RST_CUR_GAIN_I;
            cur_limit_reg    <= cpid_lev_pkg::RST_CUR_LIMIT;
            volt_limit_reg   <= cpid_lev_pkg::RST_VOLT_LIMIT;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cpid_lev_pkg::REG_POS_SETPOINT: pos_setpoint_reg <= cfg_data[SP_W-1:0];
                    cpid_lev_pkg::REG_POS_GAIN_P:   pos_gain_p_reg   <= cfg_data[GAIN_W-1:0];
                    cpid_lev_pkg::REG_POS_GAIN_I:   pos_gain_i_reg   <= cfg_data[GAIN_W-1:0];
                    cpid_lev_pkg::REG_POS_GAIN_D:   pos_gain_d_reg   <= cfg_data[GAIN_W-1:0];
                    cpid_lev_pkg::REG_CUR_GAIN_P:   cur_gain_p_reg   <= cfg_data[GAIN_W-1:0];
                    cpid_lev_pkg::REG_CUR_GAIN_I:   cur_gain_i_reg   <= cfg_data[GAIN_W-1:0];
                    cpid_lev_pkg::REG_CUR_LIMIT:    cur_limit_reg    <= cfg_data[ILIM_W-1:0];
                    cpid_lev_pkg::REG_VOLT_LIMIT:   volt_limit_reg   <= cfg_data[VLIM_W-1:0];
                    default:                        ;
                endcase
            end

            // Previous error moves on as the derivative term is formed
            if (state_reg == ST_M1)
                error_prev_reg <= err_reg;

            // Integrators with anti-windup
            if (state_reg == ST_INT_P)
                pos_integral_reg <= cpid_lev_pkg::integrate(pos_integral_reg, incr_reg,
                                                            cur_limit_ext, prod_back);
            if (state_reg == ST_INT_C)
                cur_integral_reg <= cpid_lev_pkg::integrate(cur_integral_reg, incr_reg,
                                                            volt_limit_reg, prod_back);

            // Output register valid
            if (state_reg == ST_DONE && result_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    err_reg <= err_next;
                    ie_reg  <= cur_meas;
                end
            end
            ST_M1:
            begin
                diff_reg <= cpid_lev_pkg::sat32(cpid_lev_pkg::sext(err_reg)
                                              - cpid_lev_pkg::sext(error_prev_reg));
            end
            ST_M2:    prop_reg   <= prod_scaled;
            ST_M3:    deriv_reg  <= prod_scaled;
            ST_M4:    incr_reg   <= prod_scaled;
            ST_SUM_P: demand_reg <= demand_next;
            ST_ERR_I:
            begin
                ei_reg <= $signed({{(WORD_W-DEM_W){1'b0}}, demand_reg})
                        - $signed({{(WORD_W-ILIM_W){1'b0}}, ie_reg});
            end
            ST_M6:    prop_reg <= prod_scaled;
            ST_M7:    incr_reg <= prod_scaled;
            ST_SUM_C: u_reg    <= u_next;
            ST_SCALE:
            begin
                rem_reg     <= REM_W'(u_reg) * REM_W'(cpid_lev_pkg::PWM_MAX);
                div_reg     <= REM_W'(volt_limit_reg) << (QUOT_W - 1);
                quot_reg    <= '0;
                div_cnt_reg <= DIVC_W'(QUOT_W - 1);
            end
            ST_DIV:
            begin
                if (quot_bit)
                    rem_reg <= rem_trial;
                quot_reg    <= {quot_reg[QUOT_W-2:0], quot_bit};
                div_reg     <= div_reg >> 1;
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                if (result_free)
                begin
                    result_reg.pwm_duty       <= (volt_limit_reg == '0)
                                               ? '0 : DUTY_W'(quot_reg);
                    result_reg.current_demand <= demand_reg;
                end
            end
            default: ;
        endcase
    end

    // Checks
    `CPID_ASSERT_NEXT(a_take_starts_work, clk, rst_n, sample_valid && !sample_stall, state_reg == ST_M1, "accepted sample did not start the sequencer")
    `CPID_ASSERT_SAME(a_duty_in_range, clk, rst_n, result_valid, result.pwm_duty <= DUTY_W'(cpid_lev_pkg::PWM_MAX), "duty above full scale")
    `CPID_ASSERT_NEXT(a_done_loads_result, clk, rst_n, state_reg == ST_DONE && (!result_valid || !result_stall), result_valid && state_reg == ST_IDLE, "finished item not loaded into output register")

endmodule

`default_nettype wire
